[rtl/fsed_pkg.sv]
// ----------------------------------------------------------------------------
// fsed_pkg
// Shared types, constants and encodings of the Fourier series evaluator
// ----------------------------------------------------------------------------
package fsed_pkg;

    localparam int DEF_MAX_VARS      = 16;
    localparam int DEF_MAX_HARMONICS = 8;

    // register indexes
    localparam logic [1:0] REG_BASE_FREQ = 2'd0;
    localparam logic [1:0] REG_HARMONICS = 2'd1;
    localparam logic [1:0] REG_VAR_COUNT = 2'd2;

    // commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // quarter-wave polynomial constants, Q30
    localparam logic [31:0] K_C1 = 32'd1686629713;
    localparam logic [31:0] K_C3 = 32'd693598669;
    localparam logic [31:0] K_C5 = 32'd85569306;
    localparam logic [31:0] K_C7 = 32'd5026995;
    localparam logic [31:0] K_C9 = 32'd172272;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PHASE,
        ST_WB,
        ST_HARM,
        ST_SIN_A,
        ST_SIN_B,
        ST_SIN_C,
        ST_SIN_D,
        ST_SIN_E,
        ST_SIN_F,
        ST_SIN_G,
        ST_SIN_DONE,
        ST_VAR,
        ST_RD,
        ST_RD2,
        ST_TERM,
        ST_RATE_V,
        ST_RATE_A1,
        ST_RATE_A2,
        ST_EMIT
    } fsed_state_t;

    // saturating signed add
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63]))
            sat_add = a[63] ? S64_MIN : S64_MAX;
        else
            sat_add = r;
    endfunction

endpackage

[rtl/fsed_ram.sv]
// ----------------------------------------------------------------------------
// fsed_ram
// Generic single-port write, single-port read RAM with registered read
// ----------------------------------------------------------------------------
module fsed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 272
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[rtl/fsed_rate_mul.sv]
// ----------------------------------------------------------------------------
// fsed_rate_mul
// Multi-cycle magnitude multiply by rate with shift by 24 and saturation
// ----------------------------------------------------------------------------
module fsed_rate_mul import fsed_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic [39:0]        b,
    output logic               done,
    output logic signed [63:0] y
);

    logic [63:0]  m_reg, m_next;
    logic [39:0]  b_reg, b_next;
    logic         neg_reg, neg_next;
    logic [103:0] acc_reg, acc_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic signed [63:0] y_reg, y_next;
    logic [31:0]  part;
    logic [79:0]  pp;
    logic [79:0]  sh;

    // one 32x40 partial product per cycle
    always_comb
    begin
        part = step_reg[0] ? m_reg[63:32] : m_reg[31:0];
        pp   = {8'd0, part, 40'd0} >> 40;
        pp   = 80'(part) * 80'(b_reg);
    end

    always_comb
    begin
        m_next    = m_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        y_next    = y_reg;
        sh        = acc_reg[103:24];
        if (start)
        begin
            neg_next  = a[63];
            m_next    = a[63] ? 64'(-a) : 64'(a);
            b_next    = b;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (step_reg == 3'd0)
            begin
                acc_next  = 104'(pp);
                step_next = 3'd1;
            end
            else if (step_reg == 3'd1)
            begin
                acc_next  = acc_reg + {pp[71:0], 32'd0};
                step_next = 3'd2;
            end
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (sh[79:63] != '0)
                    y_next = neg_reg ? S64_MIN : S64_MAX;
                else if (neg_reg)
                    y_next = -$signed(sh[63:0]);
                else
                    y_next = $signed(sh[63:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign y    = y_reg;

endmodule

[rtl/fourier_series_eval_with_derivatives.sv]
// ----------------------------------------------------------------------------
// fourier_series_eval_with_derivatives
// Truncated Fourier series evaluator with first and second derivatives
// ----------------------------------------------------------------------------
// channel | direction | transaction
// s_axis  | in        | load one coefficient or evaluate at a time
// m_axis  | out       | one result per variable, tlast on the final one
// cfg     | in        | register write: base_freq, harmonic_count, var_count
//
// a load is written in the idle cycle that accepts it; an evaluate computes
// the basis with the single shared multiplier, then each variable with the
// rate multiply unit, used three times per harmonic.
// after reset a clearing pass writes zero to all MAX_VARS*(2*MAX_HARMONICS+1)
// coefficient entries, one per cycle, before the first item is taken.
// each result waits in the output register until taken; the next emit stalls.
// ----------------------------------------------------------------------------
module fourier_series_eval_with_derivatives import fsed_pkg::*; #(
    parameter int MAX_VARS      = DEF_MAX_VARS,
    parameter int MAX_HARMONICS = DEF_MAX_HARMONICS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // var_index[3:0], column_index[8:4], coeff_value[40:9], time_value[72:41]
    input  logic [79:0]  s_axis_tdata,
    // cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // var_number[3:0], value[67:4], velocity[131:68], acceleration[195:132]
    output logic [199:0] m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int NCOLS = 2 * MAX_HARMONICS + 1;
    localparam int DEPTH = MAX_VARS * NCOLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = $clog2(MAX_VARS + 1);
    localparam int KW    = $clog2(MAX_HARMONICS + 1);
    localparam int HW    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;

    fsed_state_t state_reg, state_next;

    logic [31:0] freq_reg;
    logic [3:0]  harm_reg;
    logic [4:0]  vcnt_reg;
    logic [KW-1:0] kmax;
    logic [VW-1:0] nv;

    logic [AW:0]   clr_reg, clr_next;
    logic [KW-1:0] k_reg, k_next;
    logic [HW-1:0] kidx;
    logic [VW-1:0] v_reg, v_next;
    logic          half_reg, half_next;
    logic [63:0]   prod_reg, prod_next;
    logic [39:0]   wb_reg, wb_next;
    logic [39:0]   w_reg, w_next;
    logic [39:0]   ph_reg, ph_next;
    logic [31:0]   u_reg, u_next;
    logic [31:0]   u2_reg, u2_next;
    logic [31:0]   p_reg, p_next;
    logic [17:0]   qa_reg, qa_next;
    logic [17:0]   sin_reg [MAX_HARMONICS];
    logic [17:0]   cos_reg [MAX_HARMONICS];
    logic          we_s, we_c;
    logic [31:0]   cs_reg, cs_next;
    logic signed [63:0] val_reg, val_next, vel_reg, vel_next, acc_reg, acc_next;
    logic signed [63:0] e_reg, e_next, d_next;

    logic          out_valid_reg, out_valid_next;
    logic [199:0]  out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;

    // shared multiplier
    logic [63:0]   mul_a, mul_b;
    logic [63:0]   mul_y;

    // ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;

    // rate multiplier
    logic          rm_start, rm_done;
    logic signed [63:0] rm_a, rm_y;

    logic [3:0]  in_var;
    logic [4:0]  in_col;
    logic [31:0] in_coeff, in_time;
    logic        accept;
    logic [31:0] qv;
    logic [17:0] qr;
    logic [AW-1:0] row_base;
    logic signed [17:0] sk, ck;

    assign in_var   = s_axis_tdata[3:0];
    assign in_col   = s_axis_tdata[8:4];
    assign in_coeff = s_axis_tdata[40:9];
    assign in_time  = s_axis_tdata[72:41];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_CLEAR);

    // clamped counts
    always_comb
    begin
        kmax = (32'(harm_reg) > 32'(MAX_HARMONICS)) ? KW'(MAX_HARMONICS) : KW'(harm_reg);
        if (vcnt_reg == 5'd0)
            nv = VW'(1);
        else if (32'(vcnt_reg) > 32'(MAX_VARS))
            nv = VW'(MAX_VARS);
        else
            nv = VW'(vcnt_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= '0;
            harm_reg <= 4'd1;
            vcnt_reg <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_FREQ: freq_reg <= cfg_data;
                REG_HARMONICS: harm_reg <= cfg_data[3:0];
                REG_VAR_COUNT: vcnt_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    fsed_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fsed_rate_mul u_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rm_start),
        .a     (rm_a),
        .b     (w_reg),
        .done  (rm_done),
        .y     (rm_y)
    );

    assign mul_y = 64'(mul_a[31:0]) * 64'(mul_b[31:0]);
    assign row_base = AW'(32'(v_reg) * NCOLS);
    assign qv = (32'(p_reg) * 0) + p_reg;
    assign qr = (u2_reg + 32'd8192) >> 14 > 32'd65536 ? 18'd65536
                : 18'((u2_reg + 32'd8192) >> 14);
    assign kidx = HW'(k_reg - KW'(1));
    assign sk = $signed(sin_reg[kidx]);
    assign ck = $signed(cos_reg[kidx]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:     if (accept && s_axis_tuser == CMD_EVAL) state_next = ST_PHASE;
            ST_PHASE:    state_next = ST_WB;
            ST_WB:       state_next = (kmax == '0) ? ST_VAR : ST_HARM;
            ST_HARM:     state_next = ST_SIN_A;
            ST_SIN_A:    state_next = ST_SIN_B;
            ST_SIN_B:    state_next = ST_SIN_C;
            ST_SIN_C:    state_next = ST_SIN_D;
            ST_SIN_D:    state_next = ST_SIN_E;
            ST_SIN_E:    state_next = ST_SIN_F;
            ST_SIN_F:    state_next = ST_SIN_G;
            ST_SIN_G:    state_next = ST_SIN_DONE;
            ST_SIN_DONE: state_next = !half_reg ? ST_SIN_A
                                    : (k_reg == kmax) ? ST_VAR : ST_HARM;
            ST_VAR:      state_next = ST_RD;
            ST_RD:       state_next = (k_reg > kmax || kmax == '0) ? ST_EMIT : ST_RD2;
            ST_RD2:      state_next = ST_TERM;
            ST_TERM:     state_next = ST_RATE_V;
            ST_RATE_V:   if (rm_done) state_next = ST_RATE_A1;
            ST_RATE_A1:  if (rm_done) state_next = ST_RATE_A2;
            ST_RATE_A2:  if (rm_done) state_next = (k_reg == kmax) ? ST_EMIT : ST_RD;
            ST_EMIT:     if (!out_valid_reg)
                             state_next = (v_reg + VW'(1) == nv) ? ST_IDLE : ST_VAR;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next = clr_reg; k_next = k_reg; v_next = v_reg; half_next = half_reg;
        prod_next = prod_reg; wb_next = wb_reg; w_next = w_reg; ph_next = ph_reg;
        u_next = u_reg; u2_next = u2_reg; p_next = p_reg; qa_next = qa_reg;
        cs_next = cs_reg; val_next = val_reg; vel_next = vel_reg; acc_next = acc_reg;
        e_next = e_reg; d_next = '0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next = out_data_reg; out_last_next = out_last_reg;
        mul_a = '0; mul_b = '0;
        ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
        rm_start = 1'b0; rm_a = '0;
        we_s = 1'b0; we_c = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1; ram_waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept && s_axis_tuser == CMD_LOAD &&
                    32'(in_var) < 32'(MAX_VARS) && 32'(in_col) < 32'(NCOLS))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(32'(in_var) * NCOLS + 32'(in_col));
                    ram_wdata = in_coeff;
                end
                if (accept)
                    prod_next = {32'd0, in_time};
            end
            ST_PHASE:
            begin
                mul_a = {32'd0, freq_reg}; mul_b = prod_reg;
                prod_next = mul_y;
                k_next = '0;
            end
            ST_WB:
            begin
                mul_a = {32'd0, freq_reg}; mul_b = {32'd0, TWO_PI_Q29};
                wb_next = 40'((mul_y + 64'd268435456) >> 29);
                ph_next = '0;
                k_next = KW'(1);
                v_next = '0;
            end
            ST_HARM:
            begin
                ph_next = ph_reg + prod_reg[39:0];
                half_next = 1'b0;
            end
            ST_SIN_A:
            begin
                u_next = half_reg ? (32'd1 << 30) - {2'b0, ph_reg[37:8]}
                                  : {2'b0, ph_reg[37:8]};
            end
            ST_SIN_B:
            begin
                mul_a = {32'd0, u_reg}; mul_b = {32'd0, u_reg};
                u2_next = 32'(mul_y >> 30);
                p_next = K_C9;
            end
            ST_SIN_C, ST_SIN_D, ST_SIN_E, ST_SIN_F:
            begin
                mul_a = {32'd0, u2_reg}; mul_b = {32'd0, p_reg};
                case (state_reg)
                    ST_SIN_C: p_next = K_C7 - 32'(mul_y >> 30);
                    ST_SIN_D: p_next = K_C5 - 32'(mul_y >> 30);
                    ST_SIN_E: p_next = K_C3 - 32'(mul_y >> 30);
                    default:  p_next = K_C1 - 32'(mul_y >> 30);
                endcase
            end
            ST_SIN_G:
            begin
                mul_a = {32'd0, u_reg}; mul_b = {32'd0, qv};
                u2_next = 32'(mul_y >> 30);
            end
            ST_SIN_DONE:
            begin
                if (!half_reg)
                begin
                    qa_next = qr;
                    half_next = 1'b1;
                end
                else
                begin
                    we_s = 1'b1; we_c = 1'b1;
                    if (k_reg != kmax)
                        k_next = k_reg + KW'(1);
                end
            end
            ST_VAR:
            begin
                k_next = KW'(1);
                ram_raddr = row_base;
                vel_next = '0; acc_next = '0;
            end
            ST_RD:
            begin
                if (k_reg == KW'(1))
                    val_next = $signed({{16{ram_rdata[31]}}, ram_rdata, 16'd0});
                ram_raddr = row_base + AW'(2 * 32'(k_reg) - 1);
                w_next = 40'(32'(k_reg) * 64'(wb_reg));
            end
            ST_RD2:
            begin
                cs_next = ram_rdata;
                ram_raddr = row_base + AW'(2 * 32'(k_reg));
            end
            ST_TERM:
            begin
                e_next = $signed(cs_reg) * sk + $signed(ram_rdata) * ck;
                d_next = $signed(cs_reg) * ck - $signed(ram_rdata) * sk;
                rm_start = 1'b1;
                rm_a = d_next;
            end
            ST_RATE_V:
            begin
                val_next = (state_next != state_reg) ? sat_add(val_reg, e_reg) : val_reg;
                if (rm_done)
                begin
                    vel_next = sat_add(vel_reg, rm_y);
                    rm_start = 1'b1; rm_a = -e_reg;
                end
            end
            ST_RATE_A1:
            begin
                if (rm_done)
                begin
                    rm_start = 1'b1; rm_a = rm_y;
                end
            end
            ST_RATE_A2:
            begin
                if (rm_done)
                begin
                    acc_next = sat_add(acc_reg, rm_y);
                    k_next = k_reg + KW'(1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {4'd0, acc_reg, vel_reg, val_reg, 4'(v_reg)};
                    out_last_next = (v_reg + VW'(1) == nv);
                    v_next = v_reg + VW'(1);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            v_reg         <= '0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            v_reg         <= v_next;
            half_reg      <= half_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next; wb_reg <= wb_next; w_reg <= w_next; ph_reg <= ph_next;
        u_reg <= u_next; u2_reg <= u2_next; p_reg <= p_next; qa_reg <= qa_next;
        cs_reg <= cs_next; val_reg <= val_next; vel_reg <= vel_next;
        acc_reg <= acc_next; e_reg <= e_next;
        out_data_reg <= out_data_next; out_last_reg <= out_last_next;
    end

    // basis samples, quadrant applied on store
    always_ff @(posedge clk)
    begin
        if (we_s && we_c)
        begin
            case (ph_reg[39:38])
                2'd0: begin sin_reg[kidx] <= qa_reg; cos_reg[kidx] <= qr; end
                2'd1: begin sin_reg[kidx] <= qr; cos_reg[kidx] <= -qa_reg; end
                2'd2: begin sin_reg[kidx] <= -qa_reg; cos_reg[kidx] <= -qr; end
                default: begin sin_reg[kidx] <= -qr; cos_reg[kidx] <= qa_reg; end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg) else $error("result lost");
    a_clear_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(state_reg == ST_CLEAR) |-> (state_reg == ST_IDLE)) else $error("clear exit");
`endif

endmodule

[sim/fourier_series_eval_with_derivatives_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fourier_series_eval_with_derivatives_tb
// Self-checking bench: coefficient loads and evaluations under random flow
// control, results compared against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module fourier_series_eval_with_derivatives_tb import fsed_pkg::*; ();

    localparam int NV = 16;
    localparam int NH = 8;
    localparam int NC = 2 * NH + 1;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [3:0]         var_number;
        logic signed [63:0] value;
        logic signed [63:0] velocity;
        logic signed [63:0] acceleration;
        logic               last;
    } series_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    // predictor copy of registers and coefficient store
    logic [31:0]        freq_reg;
    logic [3:0]         harm_reg;
    logic [4:0]         nvar_reg;
    logic signed [31:0] coeffs [NV][NC];

    series_result_t expected_results[$];
    int     error_count;
    int     result_count;
    int     eval_count;
    longint cycle_count;
    int     stall_mode;

    fourier_series_eval_with_derivatives dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------- arithmetic helpers ----------------

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63]))
            return a[63] ? S64_MIN : S64_MAX;
        return r;
    endfunction

    // (a*b)>>24, magnitude truncated, saturated
    function automatic logic signed [63:0] scale_by_rate(input logic signed [63:0] a,
                                                         input logic [63:0] b);
        logic         neg;
        logic [63:0]  mag;
        logic [127:0] p;
        logic [103:0] sh;
        neg = a[63];
        mag = neg ? -a : a;
        p   = mag * b;
        sh  = p[127:24];
        if (sh[103:64] != 0)
            return neg ? S64_MIN : S64_MAX;
        if (neg)
            return (sh[63:0] >= 64'h8000_0000_0000_0000) ? S64_MIN : -$signed(sh[63:0]);
        return (sh[63]) ? S64_MAX : $signed(sh[63:0]);
    endfunction

    function automatic logic signed [31:0] quarter_wave(input logic [31:0] u);
        logic [63:0] uu, u2, p, s, r;
        uu = u;
        u2 = (uu * uu) >> 30;
        p  = K_C9;
        p  = K_C7 - ((u2 * p) >> 30);
        p  = K_C5 - ((u2 * p) >> 30);
        p  = K_C3 - ((u2 * p) >> 30);
        p  = K_C1 - ((u2 * p) >> 30);
        s  = (uu * p) >> 30;
        r  = (s + 64'd8192) >> 14;
        if (r > 64'd65536)
            r = 64'd65536;
        return r[31:0];
    endfunction

    // expected results of one evaluation
    task automatic predict_series(input logic [31:0] t);
        logic signed [31:0] sn [NC];
        logic signed [31:0] cs [NC];
        logic [63:0]        prod, wb, ph, w;
        logic [1:0]         q;
        logic [31:0]        u;
        logic signed [31:0] a, b;
        logic signed [63:0] val, vel, acc, e, d, csn, ccs;
        series_result_t     r;
        int kmax, nv;
        kmax = (harm_reg > NH) ? NH : harm_reg;
        nv   = (nvar_reg == 0) ? 1 : ((nvar_reg > NV) ? NV : nvar_reg);
        prod = 64'(freq_reg) * 64'(t);
        wb   = (64'(freq_reg) * 64'(TWO_PI_Q29) + (64'd1 << 28)) >> 29;
        for (int k = 1; k <= kmax; k++)
        begin
            ph = 64'(k) * prod;
            q  = ph[39:38];
            u  = {2'b00, ph[37:8]};
            a  = quarter_wave(u);
            b  = quarter_wave(32'h4000_0000 - u);
            case (q)
                2'd0: begin sn[k] = a;  cs[k] = b;  end
                2'd1: begin sn[k] = b;  cs[k] = -a; end
                2'd2: begin sn[k] = -a; cs[k] = -b; end
                default: begin sn[k] = -b; cs[k] = a; end
            endcase
        end
        for (int v = 0; v < nv; v++)
        begin
            val = 64'(coeffs[v][0]) * 64'sd65536;
            vel = 0;
            acc = 0;
            for (int k = 1; k <= kmax; k++)
            begin
                csn = coeffs[v][2*k-1];
                ccs = coeffs[v][2*k];
                w   = 64'(k) * wb;
                e   = csn * 64'(sn[k]) + ccs * 64'(cs[k]);
                d   = csn * 64'(cs[k]) - ccs * 64'(sn[k]);
                val = add_sat(val, e);
                vel = add_sat(vel, scale_by_rate(d, w));
                acc = add_sat(acc, scale_by_rate(scale_by_rate(-e, w), w));
            end
            r.var_number   = v[3:0];
            r.value        = val;
            r.velocity     = vel;
            r.acceleration = acc;
            r.last         = (v + 1 == nv);
            expected_results.push_back(r);
        end
    endtask

    // ---------------- drivers ----------------

    // valid stays up between back-to-back items and drops in gaps
    task automatic send_item(input logic cmd, input logic [3:0] row, input logic [4:0] col,
                             input logic [31:0] coeff, input logic [31:0] t);
        // random gap before bursts
        if ($urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, t, coeff, col, row};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (cmd == CMD_LOAD)
        begin
            if (col < NC)
                coeffs[row][col] = coeff;
        end
        else
        begin
            predict_series(t);
            eval_count++;
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_BASE_FREQ: freq_reg = data;
            REG_HARMONICS: harm_reg = data[3:0];
            REG_VAR_COUNT: nvar_reg = data[4:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait until all results are in, plus slack for trailing work
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_config(input logic [31:0] f, input logic [3:0] k,
                              input logic [4:0] n);
        drain();
        write_reg(REG_BASE_FREQ, f);
        write_reg(REG_HARMONICS, {28'd0, k});
        write_reg(REG_VAR_COUNT, {27'd0, n});
        cfg_valid <= 1'b0;
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 result_count);
    endtask

    always @(posedge clk)
    begin
        series_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[3:0], m_axis_tdata[67:4], m_axis_tdata[131:68],
                   m_axis_tdata[195:132], m_axis_tlast};
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 64'(got.var_number), 0);
            else
            begin
                want = expected_results.pop_front();
                if (got.var_number != want.var_number)
                    report_mismatch("var_number", 64'(got.var_number), 64'(want.var_number));
                if (got.value != want.value)
                    report_mismatch("value", got.value, want.value);
                if (got.velocity != want.velocity)
                    report_mismatch("velocity", got.velocity, want.velocity);
                if (got.acceleration != want.acceleration)
                    report_mismatch("acceleration", got.acceleration, want.acceleration);
                if (got.last != want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
            result_count++;
        end
    end

    // receiver stall pattern, mode changes over the run
    always @(negedge clk)
    begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------- tests ----------------

    function automatic logic [31:0] rand_coeff;
        case ($urandom_range(0, 4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic load_random_rows(input int rows, input int cols);
        for (int v = 0; v < rows; v++)
            for (int c = 0; c < cols; c++)
                send_item(CMD_LOAD, v[3:0], c[4:0], rand_coeff(), $urandom);
    endtask

    // reset defaults: zero store, zero frequency
    task automatic test_reset_state;
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    // extremes, out-of-range loads, clamped register values
    task automatic test_directed;
        set_config(32'h0100_0000, 4'd1, 5'd2);
        send_item(CMD_LOAD, 4'd0, 5'd0, 32'h7FFF_FFFF, 32'd0);
        send_item(CMD_LOAD, 4'd0, 5'd1, 32'h8000_0000, 32'd0);
        send_item(CMD_LOAD, 4'd0, 5'd2, 32'h0001_0000, 32'd0);
        send_item(CMD_LOAD, 4'd1, 5'd1, 32'hFFFF_0000, 32'd0);
        send_item(CMD_LOAD, 4'd15, 5'd16, 32'h1234_5678, 32'hFFFF_FFFF);
        // column past the store is dropped
        send_item(CMD_LOAD, 4'd15, 5'd31, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_LOAD, 4'd3, 5'd17, 32'h5555_5555, 32'd0);
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'd0);
        send_item(CMD_EVAL, 4'hF, 5'h1F, 32'hFFFF_FFFF, 32'h0000_4000);
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'hFFFF_FFFF);
        // zero harmonics and zero variables
        set_config(32'hFFFF_FFFF, 4'd0, 5'd0);
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'h0001_8000);
        // too many harmonics and variables, maximum frequency
        set_config(32'hFFFF_FFFF, 4'd15, 5'd31);
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'hFFFF_FFFF);
        set_config(32'h0000_0001, 4'd8, 5'd16);
        send_item(CMD_EVAL, 4'd0, 5'd0, 32'd0, 32'hAAAA_AAAA);
    endtask

    // random phases: configure, load a small set, evaluate repeatedly
    task automatic test_random_phases;
        int k, n;
        for (int ph = 0; ph < 8; ph++)
        begin
            stall_mode = ph % 3;
            k = (ph == 7) ? 8 : $urandom_range(1, 2);
            n = (ph == 7) ? 16 : $urandom_range(1, 3);
            set_config((ph % 2) ? $urandom : $urandom_range(0, 32'h0400_0000),
                       k[3:0], n[4:0]);
            // full-size phase: scattered loads over the whole store
            if (ph == 7)
            begin
                repeat (40)
                    send_item(CMD_LOAD, 4'($urandom), 5'($urandom_range(0, NC - 1)),
                              rand_coeff(), $urandom);
            end
            else
                load_random_rows(n, 2 * k + 1);
            repeat (4)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(CMD_LOAD, 4'($urandom), 5'($urandom), rand_coeff(), $urandom);
                send_item(CMD_EVAL, 4'($urandom), 5'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_LOAD;
        m_axis_tready = 1'b1;
        cfg_valid     = 1'b0;
        cfg_index     = REG_BASE_FREQ;
        cfg_data      = '0;
        freq_reg      = 32'd0;
        harm_reg      = 4'd1;
        nvar_reg      = 5'd1;
        for (int v = 0; v < NV; v++)
            for (int c = 0; c < NC; c++)
                coeffs[v][c] = 32'sd0;
        error_count   = 0;
        result_count  = 0;
        eval_count    = 0;
        cycle_count   = 0;
        stall_mode    = 1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_directed();
        test_random_phases();
        drain();

        $display("covered %0d evaluations with %0d results, registers at extremes",
                 eval_count, result_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/fsed_pkg.sv
rtl/fsed_ram.sv
rtl/fsed_rate_mul.sv
rtl/fourier_series_eval_with_derivatives.sv
sim/fourier_series_eval_with_derivatives_tb.sv
